### hdl/spfd_pkg.sv
package spfd_pkg;

  localparam int LINE_DEPTH_DEF  = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int DLY_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int MIX_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] FB_MAX    = 16'd62259;
  localparam logic [MIX_W-1:0]  MIX_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] DC_RESET  = 16'd65524;
  localparam logic [DLY_W-1:0]  DLY_RESET = 17'd1;

  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 3'd0,
    CFG_FEEDBACK = 3'd1,
    CFG_PINGPONG = 3'd2,
    CFG_MIX      = 3'd3,
    CFG_DC       = 3'd4,
    CFG_STEREO   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [OBUF_CNT_W-1:0] count;
    logic                  empty;
  } obuf_stat_t;

endpackage

### hdl/spfd_ifs.sv
interface spfd_in_if import spfd_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dry_left;
  logic signed [W-1:0] dry_right;

  modport source (output valid, output dry_left, output dry_right, input ready);
  modport sink   (input valid, input dry_left, input dry_right, output ready);
endinterface

interface spfd_out_if import spfd_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_left;
  logic signed [W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

### hdl/spfd_line.sv
module spfd_line import spfd_pkg::*; #(
  parameter int DEPTH = LINE_DEPTH_DEF,
  parameter int W     = 2 * SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/spfd_obuf.sv
module spfd_obuf import spfd_pkg::*; #(
  parameter int W = 2 * SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  output obuf_stat_t   stat
);

  logic [W-1:0]          mem [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OBUF_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OBUF_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OBUF_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + OBUF_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + OBUF_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - OBUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign stat.count = count_r;
  assign stat.empty = !pop_valid;

endmodule

### hdl/stereo_pingpong_feedback_delay_core.sv
// Stereo ping-pong feedback delay with a DC blocker in the feedback path. One sample
// pair is taken every cycle while the result buffer has room. Stage 1 holds the beat
// while its mixed result is computed and pushed to the output buffer. The rate is set
// by the filter recurrence and the single write and read port of the delay-line RAM; a
// just-written sample is forwarded to the next beat that reads it. Up to four results
// are buffered, so input keeps flowing while the output stalls until the buffer fills.
// Delay lines are not cleared after reset: a fill mark makes unwritten entries read as
// zero, so the block is ready at once. Registers are written via cfg_we / cfg_idx /
// cfg_wdata; the user must do so only while the block is idle, which is not enforced.
module stereo_pingpong_feedback_delay_core import spfd_pkg::*; #(
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  spfd_in_if.sink              in_ch,
  spfd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;
  localparam int PW = SB + 19;
  localparam logic signed [PW-1:0] HALF = PW'(32'sd32768);

  function automatic logic signed [PW-1:0] sx(input logic signed [SB-1:0] v);
    return {{(PW-SB){v[SB-1]}}, v};
  endfunction

  function automatic logic signed [PW-1:0] ux(input logic [MIX_W-1:0] v);
    return {{(PW-MIX_W){1'b0}}, v};
  endfunction

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] t;
    t = x + HALF;
    return t >>> 16;
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] x);
    logic [PW-SB:0] top;
    top = x[PW-1:SB-1];
    if ((&top) || !(|top)) begin
      return x[SB-1:0];
    end else if (x[PW-1]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  // config
  logic [DLY_W-1:0]  dly_r;
  logic [GAIN_W-1:0] fb_r;
  logic              pp_r;
  logic [MIX_W-1:0]  mix_r;
  logic [GAIN_W-1:0] dc_r;
  logic              st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= DLY_RESET;
      fb_r  <= '0;
      pp_r  <= 1'b0;
      mix_r <= '0;
      dc_r  <= DC_RESET;
      st_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_DELAY:    dly_r <= cfg_wdata[DLY_W-1:0];
        CFG_FEEDBACK: fb_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_PINGPONG: pp_r  <= cfg_wdata[0];
        CFG_MIX:      mix_r <= cfg_wdata[MIX_W-1:0];
        CFG_DC:       dc_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_STEREO:   st_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [GAIN_W-1:0] fb_c;
  logic [MIX_W-1:0]  mix_c;
  logic [MIX_W-1:0]  dry_w;
  logic [CW-1:0]     dly_x;
  logic [CW-1:0]     dly_c;

  always_comb begin
    fb_c  = (fb_r > FB_MAX) ? FB_MAX : fb_r;
    mix_c = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
    dry_w = MIX_ONE - mix_c;
    dly_x = CW'(dly_r);
    if (dly_x == '0) begin
      dly_c = CW'(1);
    end else if (dly_x > CW'(LINE_DEPTH - 1)) begin
      dly_c = CW'(LINE_DEPTH - 1);
    end else begin
      dly_c = dly_x;
    end
  end

  // write pointer, fill mark and read address
  logic          in_fire;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [CW-1:0] wp_x;
  logic [CW-1:0] rp_x;
  logic [AW-1:0] rp;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign wp_x    = CW'(wp_r);
  assign rp_x    = (wp_x >= dly_c) ? (wp_x - dly_c) : (wp_x + CW'(LINE_DEPTH) - dly_c);
  assign rp      = rp_x[AW-1:0];

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (in_fire) begin
      if (wp_r == AW'(LINE_DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + AW'(1);
      end
    end
  end

  // stage 1 registers
  logic                 s1_v_r;
  logic signed [SB-1:0] s1_dl_r, s1_dr_r;
  logic [AW-1:0]        s1_wp_r;
  logic                 s1_ok_r;
  logic                 s1_hit_r;
  logic signed [SB-1:0] byp_l_r, byp_r_r;

  logic signed [SB-1:0] prev_raw_l_r, prev_raw_r_r;
  logic signed [SB-1:0] prev_y_l_r, prev_y_r_r;

  logic signed [SB-1:0] y_l, y_r;
  logic signed [SB-1:0] raw_l, raw_r;
  logic signed [SB-1:0] o_l, o_r;

  obuf_stat_t ob_stat;

  assign in_ch.ready = (32'(ob_stat.count) + 32'(s1_v_r)) < OBUF_DEPTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      s1_v_r    <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dl_r  <= in_ch.dry_left;
      s1_dr_r  <= st_r ? in_ch.dry_right : in_ch.dry_left;
      s1_wp_r  <= wp_r;
      s1_ok_r  <= wrapped_r || (rp < wp_r);
      // entry still being written by the beat in stage 1
      s1_hit_r <= s1_v_r && (s1_wp_r == rp);
      byp_l_r  <= y_l;
      byp_r_r  <= y_r;
    end
  end

  // delay lines
  logic [2*SB-1:0] line_rdata;

  spfd_line #(
    .DEPTH (LINE_DEPTH),
    .W     (2 * SB)
  ) u_line (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_wp_r),
    .wdata ({y_l, y_r}),
    .raddr (rp),
    .rdata (line_rdata)
  );

  // stage 1 datapath
  logic signed [SB-1:0] wet_l, wet_r;
  logic signed [SB-1:0] f_l, f_r;
  logic signed [SB-1:0] src_dl, src_fl, src_dr, src_fr;
  logic signed [PW-1:0] mul_fl, mul_fr, mul_dl, mul_dr;
  logic signed [PW-1:0] rf_l, rf_r;
  logic signed [PW-1:0] mix_l, mix_r2;

  always_comb begin
    if (s1_hit_r) begin
      wet_l = byp_l_r;
      wet_r = byp_r_r;
    end else if (s1_ok_r) begin
      wet_l = line_rdata[2*SB-1:SB];
      wet_r = line_rdata[SB-1:0];
    end else begin
      wet_l = '0;
      wet_r = '0;
    end

    mul_fl = sx(wet_l) * ux(MIX_W'(fb_c));
    mul_fr = sx(wet_r) * ux(MIX_W'(fb_c));
    rf_l   = rnd(mul_fl);
    rf_r   = rnd(mul_fr);
    f_l    = rf_l[SB-1:0];
    f_r    = rf_r[SB-1:0];

    if (pp_r) begin
      src_dl = s1_dr_r;
      src_fl = f_r;
      src_dr = s1_dl_r;
      src_fr = f_l;
    end else begin
      src_dl = s1_dl_r;
      src_fl = f_l;
      src_dr = s1_dr_r;
      src_fr = f_r;
    end
    raw_l = sat(sx(src_dl) + sx(src_fl));
    raw_r = sat(sx(src_dr) + sx(src_fr));

    mul_dl = sx(prev_y_l_r) * ux(MIX_W'(dc_r));
    mul_dr = sx(prev_y_r_r) * ux(MIX_W'(dc_r));
    y_l    = sat(sx(raw_l) - sx(prev_raw_l_r) + rnd(mul_dl));
    y_r    = sat(sx(raw_r) - sx(prev_raw_r_r) + rnd(mul_dr));

    mix_l  = sx(s1_dl_r) * ux(dry_w) + sx(wet_l) * ux(mix_c);
    mix_r2 = sx(s1_dr_r) * ux(dry_w) + sx(wet_r) * ux(mix_c);
    o_l    = sat(rnd(mix_l));
    o_r    = sat(rnd(mix_r2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_l_r <= '0;
      prev_raw_r_r <= '0;
      prev_y_l_r   <= '0;
      prev_y_r_r   <= '0;
    end else if (s1_v_r) begin
      prev_raw_l_r <= raw_l;
      prev_raw_r_r <= raw_r;
      prev_y_l_r   <= y_l;
      prev_y_r_r   <= y_r;
    end
  end

  // result buffer
  logic [2*SB-1:0] ob_data;

  spfd_obuf #(
    .W (2 * SB)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data ({o_l, o_r}),
    .pop_ready (out_ch.ready),
    .pop_valid (out_ch.valid),
    .pop_data  (ob_data),
    .stat      (ob_stat)
  );

  assign out_ch.out_left  = ob_data[2*SB-1:SB];
  assign out_ch.out_right = ob_data[SB-1:0];

  // checks
  a_obuf_room: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ob_stat.count) + 32'(s1_v_r)) <= OBUF_DEPTH)
    else $error("result buffer over-committed");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (wp_r != AW'(LINE_DEPTH - 1)) |=> wp_r == $past(wp_r) + AW'(1))
    else $error("write pointer did not advance on accepted beat");

  a_wp_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (wp_r == AW'(LINE_DEPTH - 1)) |=> (wp_r == '0) && wrapped_r)
    else $error("write pointer wrap or fill mark wrong");

endmodule
